// ===== rtl/core/bchf_pkg.sv =====
`default_nettype none

package bchf_pkg;

    // Register indexes, byte address is 4 * index
    localparam logic [2:0] REG_TICK_PERIOD     = 3'd0;
    localparam logic [2:0] REG_CLICK_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_HOLD_THRESHOLD  = 3'd2;
    localparam logic [2:0] REG_REPEAT_INTERVAL = 3'd3;
    localparam logic [2:0] REG_CLICK_GAP       = 3'd4;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Key state codes
    localparam logic [2:0] ST_RELEASED = 3'd0;
    localparam logic [2:0] ST_PREPRESS = 3'd1;
    localparam logic [2:0] ST_PRELONG  = 3'd2;
    localparam logic [2:0] ST_LONGHOLD = 3'd3;
    localparam logic [2:0] ST_MULTI    = 3'd4;

    localparam logic [7:0] CLICKS_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0]  tick_period;
        logic [15:0] click_threshold;
        logic [15:0] hold_threshold;
        logic [15:0] repeat_interval;
        logic [15:0] click_gap;
    } cfg_t;

    typedef struct packed {
        logic        ev_press;
        logic        ev_first_long;
        logic        ev_hold_repeat;
        logic        ev_long_release;
        logic        ev_multi_click;
        logic        ev_release;
        logic [7:0]  clicks;
        logic [15:0] last_hold;
        logic [2:0]  fsm_state;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bchf_apb_regs.sv =====
`default_nettype none

module bchf_apb_regs
    import bchf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tick_period     <= 8'd10;
            cfg_reg.click_threshold <= 16'd20;
            cfg_reg.hold_threshold  <= 16'd1000;
            cfg_reg.repeat_interval <= 16'd200;
            cfg_reg.click_gap       <= 16'd300;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TICK_PERIOD:     cfg_reg.tick_period     <= pwdata[7:0];
                REG_CLICK_THRESHOLD: cfg_reg.click_threshold <= pwdata[15:0];
                REG_HOLD_THRESHOLD:  cfg_reg.hold_threshold  <= pwdata[15:0];
                REG_REPEAT_INTERVAL: cfg_reg.repeat_interval <= pwdata[15:0];
                REG_CLICK_GAP:       cfg_reg.click_gap       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TICK_PERIOD:     prdata = {24'd0, cfg_reg.tick_period};
            REG_CLICK_THRESHOLD: prdata = {16'd0, cfg_reg.click_threshold};
            REG_HOLD_THRESHOLD:  prdata = {16'd0, cfg_reg.hold_threshold};
            REG_REPEAT_INTERVAL: prdata = {16'd0, cfg_reg.repeat_interval};
            REG_CLICK_GAP:       prdata = {16'd0, cfg_reg.click_gap};
            default:             prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/bchf_step.sv =====
`default_nettype none

module bchf_step
    import bchf_pkg::*;
#(
    parameter int unsigned TIMER_BITS = 16
) (
    input  wire cfg_t                   cfg,
    input  wire logic                   pressed,
    input  wire logic [2:0]             mode,
    input  wire logic [TIMER_BITS-1:0]  press_time,
    input  wire logic [TIMER_BITS-1:0]  gap_time,
    input  wire logic [15:0]            repeat_count,
    input  wire logic [7:0]             click_total,
    input  wire logic [TIMER_BITS-1:0]  hold_record,
    output logic      [2:0]             mode_next,
    output logic      [TIMER_BITS-1:0]  press_time_next,
    output logic      [TIMER_BITS-1:0]  gap_time_next,
    output logic      [15:0]            repeat_count_next,
    output logic      [7:0]             click_total_next,
    output logic      [TIMER_BITS-1:0]  hold_record_next,
    output result_t                     result
);

    // compare width: timers against 16-bit thresholds
    localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic [TIMER_BITS:0] press_sum;
    logic [TIMER_BITS:0] gap_sum;
    logic [2:0]          cur_mode;
    logic                press_gt_click;
    logic                press_gt_hold;
    logic                gap_gt_limit;
    logic [CMP_W-1:0]    hold_ext;

    // saturating timer adds
    assign press_sum = {1'b0, press_time} + (TIMER_BITS + 1)'(cfg.tick_period);
    assign gap_sum   = {1'b0, gap_time} + (TIMER_BITS + 1)'(cfg.tick_period);

    always_comb begin
        if (!pressed) begin
            press_time_next = '0;
        end else if (press_sum[TIMER_BITS]) begin
            press_time_next = '1;
        end else begin
            press_time_next = press_sum[TIMER_BITS-1:0];
        end
    end

    // unused codes behave as released
    assign cur_mode = (mode > ST_MULTI) ? ST_RELEASED : mode;

    always_comb begin
        if (cur_mode != ST_MULTI) begin
            gap_time_next = '0;
        end else if (gap_sum[TIMER_BITS]) begin
            gap_time_next = '1;
        end else begin
            gap_time_next = gap_sum[TIMER_BITS-1:0];
        end
    end

    assign hold_record_next = (!pressed && cur_mode == ST_LONGHOLD) ? press_time : hold_record;

    assign press_gt_click = CMP_W'(press_time_next) > CMP_W'(cfg.click_threshold);
    assign press_gt_hold  = CMP_W'(press_time_next) > CMP_W'(cfg.hold_threshold);
    assign gap_gt_limit   = CMP_W'(gap_time_next) > CMP_W'(cfg.click_gap);

    always_comb begin
        mode_next         = cur_mode;
        repeat_count_next = repeat_count;
        click_total_next  = click_total;
        result            = '0;
        unique case (cur_mode)
            ST_PREPRESS: begin
                if (!pressed) begin
                    mode_next = ST_RELEASED;
                end else if (press_gt_click) begin
                    mode_next       = ST_PRELONG;
                    result.ev_press = 1'b1;
                end
            end
            ST_PRELONG: begin
                if (!pressed) begin
                    mode_next = ST_MULTI;
                    if (click_total != CLICKS_MAX) begin
                        click_total_next = click_total + 8'd1;
                    end
                end else if (press_gt_hold) begin
                    mode_next            = ST_LONGHOLD;
                    repeat_count_next    = cfg.repeat_interval;
                    result.ev_first_long = 1'b1;
                end
            end
            ST_LONGHOLD: begin
                if (repeat_count != 16'd0) begin
                    repeat_count_next = (repeat_count > {8'd0, cfg.tick_period}) ?
                                        repeat_count - {8'd0, cfg.tick_period} : 16'd0;
                end else begin
                    repeat_count_next     = cfg.repeat_interval;
                    result.ev_hold_repeat = 1'b1;
                end
                if (!pressed) begin
                    mode_next              = ST_RELEASED;
                    result.ev_long_release = 1'b1;
                    result.ev_release      = 1'b1;
                end
            end
            ST_MULTI: begin
                if (gap_gt_limit) begin
                    mode_next             = ST_RELEASED;
                    result.ev_multi_click = 1'b1;
                    result.ev_release     = 1'b1;
                end else if (press_gt_click) begin
                    mode_next = ST_PRELONG;
                end
            end
            default: begin
                click_total_next = 8'd0;
                if (pressed) begin
                    mode_next = ST_PREPRESS;
                end
            end
        endcase
        result.clicks    = click_total_next;
        result.last_hold = hold_ext[15:0];
        result.fsm_state = mode_next;
    end

    assign hold_ext = CMP_W'(hold_record_next);

endmodule

`default_nettype wire

// ===== rtl/core/button_click_hold_event_fsm_core.sv =====
// Each result is registered: it enters the result register if free, else the skid entry first.
// Throughput: one tick per cycle while s_ready is high; the whole state update is one combinational pass.
// A two-entry output buffer (result register plus skid) keeps s_ready high while
// one result waits on m_ready.
// Reset (aresetn low, synchronous): key state released, all timers and counts zero,
// registers back to their defaults, output buffer empty.
`default_nettype none

module button_click_hold_event_fsm_core
    import bchf_pkg::*;
#(
    parameter int unsigned TIMER_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // config port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    // poll tick input
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_pressed,
    // event output
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_ev_press,
    output logic                   m_ev_first_long,
    output logic                   m_ev_hold_repeat,
    output logic                   m_ev_long_release,
    output logic                   m_ev_multi_click,
    output logic                   m_ev_release,
    output logic      [7:0]        m_clicks,
    output logic      [15:0]       m_last_hold,
    output logic      [2:0]        m_fsm_state
);

    cfg_t cfg;

    // key state
    logic [2:0]            mode_reg;
    logic [TIMER_BITS-1:0] press_time_reg;
    logic [TIMER_BITS-1:0] gap_time_reg;
    logic [15:0]           repeat_count_reg;
    logic [7:0]            click_total_reg;
    logic [TIMER_BITS-1:0] hold_record_reg;

    logic [2:0]            mode_next;
    logic [TIMER_BITS-1:0] press_time_next;
    logic [TIMER_BITS-1:0] gap_time_next;
    logic [15:0]           repeat_count_next;
    logic [7:0]            click_total_next;
    logic [TIMER_BITS-1:0] hold_record_next;
    result_t               step_res;

    // output buffer: result register and skid entry
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;

    logic    in_xfer;
    logic    out_free;

    bchf_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bchf_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .cfg               (cfg),
        .pressed           (s_pressed),
        .mode              (mode_reg),
        .press_time        (press_time_reg),
        .gap_time          (gap_time_reg),
        .repeat_count      (repeat_count_reg),
        .click_total       (click_total_reg),
        .hold_record       (hold_record_reg),
        .mode_next         (mode_next),
        .press_time_next   (press_time_next),
        .gap_time_next     (gap_time_next),
        .repeat_count_next (repeat_count_next),
        .click_total_next  (click_total_next),
        .hold_record_next  (hold_record_next),
        .result            (step_res)
    );

    // Input side only stalls when the skid entry is occupied.
    assign s_ready  = ~skid_valid_reg;
    assign in_xfer  = s_valid & s_ready;
    // result register can take new data this cycle
    assign out_free = ~out_valid_reg | m_ready;

    // State advances once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= ST_RELEASED;
            press_time_reg   <= '0;
            gap_time_reg     <= '0;
            repeat_count_reg <= '0;
            click_total_reg  <= '0;
            hold_record_reg  <= '0;
        end else if (in_xfer) begin
            mode_reg         <= mode_next;
            press_time_reg   <= press_time_next;
            gap_time_reg     <= gap_time_next;
            repeat_count_reg <= repeat_count_next;
            click_total_reg  <= click_total_next;
            hold_record_reg  <= hold_record_next;
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free) begin
            // skid drains first; a new transfer only arrives when skid is empty
            out_valid_next  = skid_valid_reg | in_xfer;
            skid_valid_next = 1'b0;
        end else if (in_xfer) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (in_xfer) begin
                out_reg <= step_res;
            end
        end else if (in_xfer) begin
            skid_reg <= step_res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_ev_press        = out_reg.ev_press;
    assign m_ev_first_long   = out_reg.ev_first_long;
    assign m_ev_hold_repeat  = out_reg.ev_hold_repeat;
    assign m_ev_long_release = out_reg.ev_long_release;
    assign m_ev_multi_click  = out_reg.ev_multi_click;
    assign m_ev_release      = out_reg.ev_release;
    assign m_clicks          = out_reg.clicks;
    assign m_last_hold       = out_reg.last_hold;
    assign m_fsm_state       = out_reg.fsm_state;

    // skid entry is only ever filled behind a held result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty result register");

    // release flag is raised exactly by one of the two ending events
    a_release_source: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ev_release == (m_ev_long_release | m_ev_multi_click)))
        else $error("release flag inconsistent with ending events");

    // an ending event always returns the key to released
    a_release_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ev_release) |-> (m_fsm_state == ST_RELEASED))
        else $error("release reported outside released state");

    // a skid-held transfer moves into the result register once it frees up
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry failed to drain");

endmodule

`default_nettype wire
